/* rtl/qkud_pkg.sv */
// Package: shared types, codes and constants of the query keyword URL decoder.
package qkud_pkg;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned KeyLen = 8;
  localparam logic [7:0] MaxLenReset = 8'd39;

  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChK     = 8'h6B;

  // register index, decoded from paddr[2]
  localparam logic RegMaxLen = 1'b0;

  typedef enum logic [1:0] {
    PH_SEEK_Q = 2'd0,
    PH_MATCH  = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_LOWER = 2'd2,
    ESC_OTHER = 2'd3
  } esc_e;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_e;

  // results caused by one item, plus the running emitted count
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    kind_e [MaxRes-1:0]     kinds;
    logic [1:0]             n;
    logic [7:0]             cnt;
  } res_acc_t;

  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6B; // k
      3'd1:    c = 8'h65; // e
      3'd2:    c = 8'h79; // y
      3'd3:    c = 8'h77; // w
      3'd4:    c = 8'h6F; // o
      3'd5:    c = 8'h72; // r
      3'd6:    c = 8'h64; // d
      default: c = 8'h3D; // =
    endcase
    return c;
  endfunction

endpackage

/* rtl/qkud_core.sv */
// Input register, request state and single-pass decode of one item.
module qkud_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eor_i,
  input  logic [7:0]          max_len_i,
  input  logic                buf_free_i,
  output logic                res_load_o,
  output qkud_pkg::res_acc_t  res_o
);

  logic                  s1_valid_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_eor_q;
  qkud_pkg::phase_e      phase_q, phase_d;
  logic [3:0]            kmc_q, kmc_d;
  qkud_pkg::esc_e        esc_q, esc_d;
  logic [3:0]            fhd_q, fhd_d;
  logic [7:0]            cnt_q;
  qkud_pkg::res_acc_t    acc;
  logic                  fire;
  logic                  hex_ok;
  logic                  hex_lower;
  logic [3:0]            hex_v;

  function automatic qkud_pkg::res_acc_t put_res(input qkud_pkg::res_acc_t a,
                                                 input logic [7:0] b,
                                                 input qkud_pkg::kind_e k);
    qkud_pkg::res_acc_t r;
    r = a;
    r.bytes[a.n] = b;
    r.kinds[a.n] = k;
    r.n = a.n + 2'd1;
    return r;
  endfunction

  function automatic qkud_pkg::res_acc_t put_data(input qkud_pkg::res_acc_t a,
                                                  input logic [7:0] b,
                                                  input logic [7:0] lim);
    qkud_pkg::res_acc_t r;
    r = a;
    if (a.cnt < lim) begin
      r = put_res(a, b, qkud_pkg::KIND_DATA);
      r.cnt = a.cnt + 8'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] v, input logic lower);
    logic [7:0] c;
    if (v < 4'd10) c = 8'h30 + {4'd0, v};
    else if (lower) c = 8'h57 + {4'd0, v};
    else c = 8'h37 + {4'd0, v};
    return c;
  endfunction

  // emits a pending escape literally
  function automatic qkud_pkg::res_acc_t flush(input qkud_pkg::res_acc_t a,
                                               input qkud_pkg::esc_e e,
                                               input logic [3:0] f,
                                               input logic [7:0] lim);
    qkud_pkg::res_acc_t r;
    r = a;
    if (e != qkud_pkg::ESC_NONE) begin
      r = put_data(r, qkud_pkg::ChPct, lim);
      if (e != qkud_pkg::ESC_PCT) begin
        r = put_data(r, digit_char(f, e == qkud_pkg::ESC_LOWER), lim);
      end
    end
    return r;
  endfunction

  // hex digit classification
  always_comb begin
    hex_ok    = 1'b1;
    hex_lower = 1'b0;
    hex_v     = 4'd0;
    if (s1_byte_q >= 8'h30 && s1_byte_q <= 8'h39) begin
      hex_v = s1_byte_q[3:0];
    end else if (s1_byte_q >= 8'h41 && s1_byte_q <= 8'h46) begin
      hex_v = s1_byte_q[3:0] + 4'd9;
    end else if (s1_byte_q >= 8'h61 && s1_byte_q <= 8'h66) begin
      hex_v     = s1_byte_q[3:0] + 4'd9;
      hex_lower = 1'b1;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    logic do_plain;
    acc       = '0;
    acc.cnt   = cnt_q;
    phase_d   = phase_q;
    kmc_d     = kmc_q;
    esc_d     = esc_q;
    fhd_d     = fhd_q;
    do_plain  = 1'b0;
    if (s1_eor_q) begin
      if (phase_q == qkud_pkg::PH_VALUE) acc = flush(acc, esc_q, fhd_q, max_len_i);
      acc = put_res(acc, 8'd0,
                    (phase_q == qkud_pkg::PH_VALUE || phase_q == qkud_pkg::PH_DONE) ?
                    qkud_pkg::KIND_FOUND : qkud_pkg::KIND_NOT_FOUND);
      phase_d = qkud_pkg::PH_SEEK_Q;
      kmc_d   = 4'd0;
      esc_d   = qkud_pkg::ESC_NONE;
      fhd_d   = 4'd0;
      acc.cnt = 8'd0;
    end else begin
      unique case (phase_q)
        qkud_pkg::PH_SEEK_Q: begin
          if (s1_byte_q == qkud_pkg::ChQmark) phase_d = qkud_pkg::PH_MATCH;
        end
        qkud_pkg::PH_MATCH: begin
          if (kmc_q < 4'(qkud_pkg::KeyLen) && s1_byte_q == qkud_pkg::key_char(kmc_q[2:0])) begin
            kmc_d = kmc_q + 4'd1;
            if (kmc_d == 4'(qkud_pkg::KeyLen)) begin
              phase_d = qkud_pkg::PH_VALUE;
              kmc_d   = 4'd0;
            end
          end else begin
            kmc_d = (s1_byte_q == qkud_pkg::ChK) ? 4'd1 : 4'd0;
          end
        end
        qkud_pkg::PH_VALUE: begin
          if (s1_byte_q == qkud_pkg::ChAmp || s1_byte_q == qkud_pkg::ChSpace) begin
            acc     = flush(acc, esc_q, fhd_q, max_len_i);
            esc_d   = qkud_pkg::ESC_NONE;
            fhd_d   = 4'd0;
            phase_d = qkud_pkg::PH_DONE;
          end else if (esc_q == qkud_pkg::ESC_PCT && hex_ok) begin
            fhd_d = hex_v;
            esc_d = hex_lower ? qkud_pkg::ESC_LOWER : qkud_pkg::ESC_OTHER;
          end else if (esc_q != qkud_pkg::ESC_NONE && esc_q != qkud_pkg::ESC_PCT && hex_ok) begin
            acc   = put_data(acc, {fhd_q, hex_v}, max_len_i);
            esc_d = qkud_pkg::ESC_NONE;
            fhd_d = 4'd0;
          end else begin
            acc      = flush(acc, esc_q, fhd_q, max_len_i);
            esc_d    = qkud_pkg::ESC_NONE;
            fhd_d    = 4'd0;
            do_plain = 1'b1;
          end
          if (do_plain) begin
            if (s1_byte_q == qkud_pkg::ChPct) esc_d = qkud_pkg::ESC_PCT;
            else if (s1_byte_q == qkud_pkg::ChPlus) acc = put_data(acc, qkud_pkg::ChSpace, max_len_i);
            else acc = put_data(acc, s1_byte_q, max_len_i);
          end
        end
        default: ; // value done: bytes ignored until end of request
      endcase
    end
  end

  // an item with no result retires without waiting for the result buffer
  assign fire       = s1_valid_q && (acc.n == 2'd0 || buf_free_i);
  assign in_ready_o = !s1_valid_q || fire;
  assign res_load_o = fire && (acc.n != 2'd0);
  assign res_o      = acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= qkud_pkg::PH_SEEK_Q;
      kmc_q      <= 4'd0;
      esc_q      <= qkud_pkg::ESC_NONE;
      fhd_q      <= 4'd0;
      cnt_q      <= 8'd0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (fire) begin
        phase_q <= phase_d;
        kmc_q   <= kmc_d;
        esc_q   <= esc_d;
        fhd_q   <= fhd_d;
        cnt_q   <= acc.cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_eor_q  <= in_eor_i;
    end
  end

endmodule

/* rtl/qkud_res_buf.sv */
// Result register: holds up to three results of one item and hands them out in order.
module qkud_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  qkud_pkg::res_acc_t  res_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [7:0]          byte_o,
  output logic [1:0]          kind_o,
  output logic                last_o
);

  logic [qkud_pkg::MaxRes-1:0][7:0] bytes_q;
  qkud_pkg::kind_e [qkud_pkg::MaxRes-1:0] kinds_q;
  logic [1:0] n_q;
  logic [1:0] idx_q;
  logic       take;

  assign valid_o = (n_q != 2'd0);
  assign last_o  = (idx_q == n_q - 2'd1);
  assign byte_o  = bytes_q[idx_q];
  assign kind_o  = kinds_q[idx_q];
  assign take    = valid_o && ready_i;
  assign free_o  = !valid_o || (take && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      n_q   <= res_i.n;
      idx_q <= 2'd0;
    end else if (take) begin
      if (last_o) n_q <= 2'd0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= res_i.bytes;
      kinds_q <= res_i.kinds;
    end
  end

endmodule

/* rtl/query_keyword_url_decoder.sv */
// Top level: query keyword URL decoder with stream ports and an APB register port.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata = in_byte, tlast = end_of_request
//  m_axis   | out | m_axis_tvalid/tready   | tdata = out_byte, tuser = result_kind,
//           |     |                        | tlast = last
//  apb      | in  | psel/penable/pready    | reg 0 at 0x0: max_len[7:0]
//
// An item is held in the input register, then is decoded in a single pass
// into the result register. Items with at most one result sustain one per cycle
// unless the output stalls; an item with several results holds the result register
// until its last result is taken, stalling the input. Items with no result never
// wait on the output. Reset clears the request state and sets max_len to 39. A stalled
// output holds its item; the input register keeps accepting as long as it can drain.
module query_keyword_url_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_request
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast,   // last result of the item
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               [7:0] max_len_q;
  logic                     buf_free;
  logic                     res_load;
  qkud_pkg::res_acc_t       res;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == qkud_pkg::RegMaxLen);
  assign prdata = (paddr[2] == qkud_pkg::RegMaxLen) ? {24'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= qkud_pkg::MaxLenReset;
    end else if (cfg_wr) begin
      max_len_q <= pwdata[7:0];
    end
  end

  qkud_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eor_i   (s_axis_tlast),
    .max_len_i  (max_len_q),
    .buf_free_i (buf_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  qkud_res_buf u_res_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res),
    .free_o  (buf_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .kind_o  (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

endmodule

/* rtl/qkud_checker.sv */
// Port-level assertions for the query keyword URL decoder, bound to the top level.
module qkud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast,
  input logic       pready
);

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // end results carry a zero byte and close the item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != qkud_pkg::KIND_DATA |->
      m_axis_tdata == 8'd0 && m_axis_tlast)
    else $error("end result not last or not zero");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined result kind");

  // with the output empty the input never backs up
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind query_keyword_url_decoder qkud_checker u_qkud_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

/* verif/query_keyword_url_decoder_test.sv */
// Testbench: random and directed request streams checked against a query keyword decoder model.
`timescale 1ns / 100ps

module query_keyword_url_decoder_test;

  localparam int unsigned SettleCycles = 4;     // input register + result register, with margin
  localparam int unsigned StallLimit = 3000;    // cycles with no handshake at all
  localparam int unsigned LongHold = 150;       // receiver hold-off for the back-pressure test
  localparam int unsigned MaxReports = 10;
  localparam logic [63:0] KeyText = "keyword=";
  localparam logic [2:0] MaxLenAddr = {qkud_pkg::RegMaxLen, 2'b00};
  localparam logic [7:0] ChZero = "0";
  localparam logic [7:0] ChLowA = "a";
  localparam logic [7:0] ChUpA = "A";

  typedef struct packed {
    logic [7:0]       data;
    qkud_pkg::kind_e  kind;
    logic             last;
  } decode_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;  // end_of_request
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic [1:0]  m_axis_tuser;         // [1:0] result_kind
  logic        m_axis_tlast;         // last result of the item
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  query_keyword_url_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared state: idle rates, expected results, error bookkeeping
  // ---------------------------------------------------------------------------
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_left = 0;      // loaded by a test, counted down by the receiver
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;

  decode_result_t pending_results[$];  // decoded bytes and end markers still to come
  decode_result_t item_results[$];     // staging for the item being predicted
  logic [8:0]     request_q[$];        // {end_of_request, byte} of the request being built

  // Decoder state as the block should hold it
  qkud_pkg::phase_e req_phase = qkud_pkg::PH_SEEK_Q;
  int unsigned      key_hits = 0;
  qkud_pkg::esc_e   esc = qkud_pkg::ESC_NONE;
  logic [3:0]       hi_nibble = '0;
  logic [7:0]       out_count = '0;
  logic [7:0]       max_len_cfg = qkud_pkg::MaxLenReset;

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] key_byte(input int unsigned idx);
    return KeyText[8*(qkud_pkg::KeyLen-1-idx) +: 8];
  endfunction

  // 0..15 for a hex digit, 16 for anything else; lower set for a-f
  function automatic logic [4:0] hex_digit(input logic [7:0] c, output logic lower);
    lower = 1'b0;
    if (c >= "0" && c <= "9") return 5'(c - ChZero);
    if (c >= "A" && c <= "F") return 5'(c - ChUpA + 8'd10);
    if (c >= "a" && c <= "f") begin
      lower = 1'b1;
      return 5'(c - ChLowA + 8'd10);
    end
    return 5'd16;
  endfunction

  // decoded byte, subject to the max_len cap
  function automatic void emit_byte(input logic [7:0] b);
    if (out_count < max_len_cfg) begin
      out_count++;
      item_results.push_back('{data: b, kind: qkud_pkg::KIND_DATA, last: 1'b0});
    end
  endfunction

  // a cut-off escape goes out literally: '%' and the pending digit as it was typed
  function automatic void flush_escape();
    logic [7:0] digit;
    if (esc == qkud_pkg::ESC_PCT) begin
      emit_byte(qkud_pkg::ChPct);
    end else if (esc != qkud_pkg::ESC_NONE) begin
      if (hi_nibble < 4'd10) digit = ChZero + 8'(hi_nibble);
      else if (esc == qkud_pkg::ESC_LOWER) digit = ChLowA + 8'(hi_nibble) - 8'd10;
      else digit = ChUpA + 8'(hi_nibble) - 8'd10;
      emit_byte(qkud_pkg::ChPct);
      emit_byte(digit);
    end
    esc = qkud_pkg::ESC_NONE;
    hi_nibble = '0;
  endfunction

  function automatic void decode_value_byte(input logic [7:0] c);
    logic       lower;
    logic [4:0] v;
    v = hex_digit(c, lower);
    if (esc == qkud_pkg::ESC_PCT) begin
      if (v < 5'd16) begin
        hi_nibble = v[3:0];
        esc = lower ? qkud_pkg::ESC_LOWER : qkud_pkg::ESC_OTHER;
        return;
      end
      flush_escape();
    end else if (esc != qkud_pkg::ESC_NONE) begin
      if (v < 5'd16) begin
        emit_byte({hi_nibble, v[3:0]});
        esc = qkud_pkg::ESC_NONE;
        hi_nibble = '0;
        return;
      end
      flush_escape();
    end
    // the failing byte is decoded afresh
    if (c == qkud_pkg::ChPct) esc = qkud_pkg::ESC_PCT;
    else if (c == qkud_pkg::ChPlus) emit_byte(qkud_pkg::ChSpace);
    else emit_byte(c);
  endfunction

  function automatic void predict_request_byte(input logic [7:0] c, input logic eor);
    logic found;
    item_results.delete();
    if (eor) begin
      found = (req_phase == qkud_pkg::PH_VALUE) || (req_phase == qkud_pkg::PH_DONE);
      if (req_phase == qkud_pkg::PH_VALUE) flush_escape();
      item_results.push_back('{data: 8'h00,
                               kind: found ? qkud_pkg::KIND_FOUND : qkud_pkg::KIND_NOT_FOUND,
                               last: 1'b0});
      req_phase = qkud_pkg::PH_SEEK_Q;
      key_hits = 0;
      esc = qkud_pkg::ESC_NONE;
      hi_nibble = '0;
      out_count = '0;
    end else begin
      case (req_phase)
        qkud_pkg::PH_SEEK_Q: begin
          if (c == qkud_pkg::ChQmark) req_phase = qkud_pkg::PH_MATCH;
        end
        qkud_pkg::PH_MATCH: begin
          if (c == key_byte(key_hits)) begin
            key_hits++;
            if (key_hits == qkud_pkg::KeyLen) begin
              req_phase = qkud_pkg::PH_VALUE;
              key_hits = 0;
            end
          end else begin
            // a mismatching 'k' may start the key over
            key_hits = (c == qkud_pkg::ChK) ? 1 : 0;
          end
        end
        qkud_pkg::PH_VALUE: begin
          if (c == qkud_pkg::ChAmp || c == qkud_pkg::ChSpace) begin
            flush_escape();
            req_phase = qkud_pkg::PH_DONE;
          end else begin
            decode_value_byte(c);
          end
        end
        default: ;  // rest of the request is ignored
      endcase
    end
    if (item_results.size() > 0) item_results[item_results.size()-1].last = 1'b1;
    foreach (item_results[i]) pending_results.push_back(item_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    decode_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result data=%02h kind=%0d last=%0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = pending_results.pop_front();
        // fields shown as data/kind/last
        if (m_axis_tdata !== want.data || m_axis_tuser !== want.kind ||
            m_axis_tlast !== want.last)
          flag_error($sformatf("result mismatch: exp %02h/%0d/%0b, got %02h/%0d/%0b",
                               want.data, want.kind, want.last,
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", StallLimit);
        $display("** query_keyword_url_decoder: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One item on the input stream; each cycle idles with the sender's idle rate.
  task automatic send_item(input logic [7:0] b, input logic eor);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = eor;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request_byte(b, eor);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // End of request; its byte is don't-care, so it is random
  task automatic end_request();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Sender stops and waits until every expected result is out, then lets the pipe settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Only called while the block is idle
  task automatic set_max_len(input logic [7:0] v);
    logic [31:0] rd;
    apb_access(1'b1, MaxLenAddr, {24'h0, v}, rd);
    max_len_cfg = v;
    apb_access(1'b0, MaxLenAddr, '0, rd);
    if (rd !== {24'h0, v})
      flag_error($sformatf("max_len readback: exp %08h, got %08h", {24'h0, v}, rd));
  endtask

  function automatic logic [7:0] value_char();
    case ($urandom_range(0, 9))
      0, 1:    return qkud_pkg::ChPct;
      2:       return qkud_pkg::ChPlus;
      3:       return ChZero + 8'($urandom_range(0, 9));
      4:       return ChLowA + 8'($urandom_range(0, 5));
      5:       return ChUpA + 8'($urandom_range(0, 5));
      6:       return 8'($urandom_range(0, 255));
      7:       return "g" + 8'($urandom_range(0, 19));
      default: return ChLowA + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) request_q.push_back({1'b0, s[i]});
  endfunction

  // Mostly well-formed requests with random content, the rest noise or broken keys
  function automatic void build_request();
    string       junk;
    int unsigned n;
    request_q.delete();
    junk = "kexy=&";
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 12);
        repeat (n) request_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      end
      1: begin
        // key broken off part way
        request_q.push_back({1'b0, qkud_pkg::ChQmark});
        n = $urandom_range(1, qkud_pkg::KeyLen - 1);
        for (int i = 0; i < n; i++) request_q.push_back({1'b0, key_byte(i)});
        request_q.push_back({1'b0, value_char()});
        n = $urandom_range(0, 3);
        repeat (n) request_q.push_back({1'b0, value_char()});
      end
      2: begin
        // key without a question mark ahead of it
        queue_text("keyword=");
        n = $urandom_range(0, 4);
        repeat (n) request_q.push_back({1'b0, value_char()});
      end
      default: begin
        n = $urandom_range(0, 4);
        repeat (n) request_q.push_back({1'b0, ChLowA + 8'($urandom_range(0, 25))});
        request_q.push_back({1'b0, qkud_pkg::ChQmark});
        n = $urandom_range(0, 5);
        repeat (n) request_q.push_back({1'b0, junk[$urandom_range(0, 5)]});
        queue_text("keyword=");
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 10);
        repeat (n) request_q.push_back({1'b0, value_char()});
        case ($urandom_range(0, 2))
          0:       request_q.push_back({1'b0, qkud_pkg::ChAmp});
          1:       request_q.push_back({1'b0, qkud_pkg::ChSpace});
          default: ;
        endcase
        n = $urandom_range(0, 3);
        repeat (n) request_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      end
    endcase
    request_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Plus, lower-case escape, escape of zero, bad escape, escape cut by '&', bytes
  // after the value, a restarted key, and an escape cut by the end of request.
  task automatic test_directed();
    logic [31:0] rd;
    apb_access(1'b0, MaxLenAddr, '0, rd);
    if (rd !== {24'h0, qkud_pkg::MaxLenReset})
      flag_error($sformatf("max_len after reset: exp %08h, got %08h",
                           {24'h0, qkud_pkg::MaxLenReset}, rd));
    send_text("?kkeyword=+%4a%00%g%F&");
    send_item(8'hFF, 1'b0);
    end_request();
    send_text("?keyword=%e");
    end_request();
    drain();
  endtask

  // Cap extremes: nothing at 0, a tight cap at 3, then the cap left at 255
  task automatic test_max_len_extremes();
    set_max_len(8'd0);
    send_text("?keyword=ab%41");
    end_request();
    drain();
    set_max_len(8'd3);
    send_text("?keyword=abcdef");
    end_request();
    drain();
    set_max_len(8'd255);
  endtask

  // Output held off long enough to back the block up, then a mid-value pause
  task automatic test_back_pressure();
    hold_left = LongHold;
    send_text("?keyword=");
    repeat (40) send_item(ChLowA + 8'($urandom_range(0, 25)), 1'b0);
    drain();
    repeat (20) send_item(value_char(), 1'b0);
    end_request();
    drain();
  endtask

  task automatic test_random_requests(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input logic [7:0] cap, input int unsigned n_items);
    int unsigned sent;
    logic [8:0]  it;
    set_max_len(cap);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      build_request();
      while (request_q.size() != 0) begin
        it = request_q.pop_front();
        send_item(it[7:0], it[8]);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_max_len_extremes();
    test_back_pressure();
    test_random_requests(19, 67, 8'($urandom_range(1, 254)), 40);
    test_random_requests(67, 19, 8'd5, 40);
    test_random_requests(0, 0, qkud_pkg::MaxLenReset, 40);

    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("** query_keyword_url_decoder: PASSED **");
    end else begin
      $display("** query_keyword_url_decoder: FAILED **");
    end
    $finish;
  end

endmodule
